// File: hw/rtl/bsf_pkg.sv
package bsf_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 8;
   localparam int CNT_W6  = 6;

   // request codes
   localparam logic [1:0] REQ_FRAME  = 2'd0;
   localparam logic [1:0] REQ_SET    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [15:0]        ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [CNT_W6-1:0]  MIN_FRAME_BYTES = 6'd34;
   localparam logic [CNT_W6-1:0]  ETYPE_POS_HI    = 6'd12;
   localparam logic [CNT_W6-1:0]  ETYPE_POS_LO    = 6'd13;
   localparam logic [CNT_W6-1:0]  SRC_POS_FIRST   = 6'd26;
   localparam logic [CNT_W6-1:0]  SRC_POS_LAST    = 6'd29;
   localparam logic [VALUE_W-1:0] BLOCKED_VALUE   = 8'd1;

   // what an accepted request leads to
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_RESULT,
      KIND_SCAN
   } kind_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic scan;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic     clear_done;
      kind_type kind;
      logic     scan_done;
   } status_type;

endpackage

// File: hw/rtl/bsf_if.sv
interface bsf_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic [7:0]                   byte_value;
   logic                         last_byte;
   logic [bsf_pkg::KEY_W-1:0]    table_key;
   logic [bsf_pkg::VALUE_W-1:0]  table_value;

   modport source (output valid, req_type, byte_value, last_byte, table_key, table_value,
                   input ready);
   modport sink (input valid, req_type, byte_value, last_byte, table_key, table_value,
                 output ready);
endinterface

interface bsf_rsp_if;
   logic       valid;
   logic       ready;
   logic       verdict;
   logic [1:0] status;
   logic       key_found;

   modport source (output valid, verdict, status, key_found, input ready);
   modport sink (input valid, verdict, status, key_found, output ready);
endinterface

// File: hw/rtl/bsf_ctrl.sv
module bsf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bsf_pkg::status_type status,
   output bsf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (status.kind)
                  bsf_pkg::KIND_RESULT: state_in = S_RESP;
                  bsf_pkg::KIND_SCAN:   state_in = S_SCAN;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // hold the result until the output register is free
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/bsf_dp.sv
module bsf_dp #(
   parameter int TABLE_ENTRIES = bsf_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bsf_pkg::cmd_type            cmd,
   output bsf_pkg::status_type         status,
   input  logic [1:0]                  req_type,
   input  logic [7:0]                  byte_value,
   input  logic                        last_byte,
   input  logic [bsf_pkg::KEY_W-1:0]   table_key,
   input  logic [bsf_pkg::VALUE_W-1:0] table_value,
   output logic                        verdict,
   output logic [1:0]                  rsp_status,
   output logic                        key_found
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_W = bsf_pkg::KEY_W;
   localparam int VAL_W = bsf_pkg::VALUE_W;

   // header capture
   logic [5:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [15:0]      ether_ff, ether_in;
   logic [KEY_W-1:0] src_ff, src_in;
   logic [5:0]       cnt_nx;
   logic [15:0]      ether_nx;
   logic [KEY_W-1:0] src_nx;
   logic             lookup_nx;
   bsf_pkg::kind_type req_kind;

   // pending operation
   logic [1:0]       op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;

   // table memories: key memory carries the valid mark in its top bit
   logic [KEY_W:0]   key_mem [TABLE_ENTRIES];
   logic [VAL_W-1:0] val_mem [TABLE_ENTRIES];
   logic             key_we, val_we;
   logic [IDX_W-1:0] key_wa, val_wa;
   logic [KEY_W:0]   key_wd;
   logic [VAL_W-1:0] val_wd;

   // scan
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0] scan_addr;
   logic             rd_live_ff, rd_live_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [KEY_W:0]   rd_entry_ff;
   logic [VAL_W-1:0] rd_val_ff;
   logic             have_free_ff, have_free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             hit, free_any, finish, issue;
   logic [IDX_W-1:0] free_pick;

   // result and output registers
   logic             res_verdict_ff, res_verdict_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             res_found_ff, res_found_in;
   logic             out_verdict_ff;
   logic [1:0]       out_status_ff;
   logic             out_found_ff;

   always_comb begin
      ether_nx = ether_ff;
      src_nx   = src_ff;
      cnt_nx   = hdr_cnt_ff;
      if (hdr_cnt_ff == bsf_pkg::ETYPE_POS_HI || hdr_cnt_ff == bsf_pkg::ETYPE_POS_LO) begin
         ether_nx = {ether_ff[7:0], byte_value};
      end else if (hdr_cnt_ff >= bsf_pkg::SRC_POS_FIRST &&
                   hdr_cnt_ff <= bsf_pkg::SRC_POS_LAST) begin
         src_nx = {src_ff[KEY_W-9:0], byte_value};
      end
      if (hdr_cnt_ff < bsf_pkg::MIN_FRAME_BYTES) begin
         cnt_nx = hdr_cnt_ff + 6'd1;
      end
      lookup_nx = (cnt_nx >= bsf_pkg::MIN_FRAME_BYTES) &&
                  (ether_nx == bsf_pkg::ETHERTYPE_IPV4);
   end

   always_comb begin
      req_kind = bsf_pkg::KIND_NONE;
      case (req_type) inside
         bsf_pkg::REQ_FRAME: begin
            if (last_byte) begin
               req_kind = lookup_nx ? bsf_pkg::KIND_SCAN : bsf_pkg::KIND_RESULT;
            end
         end
         bsf_pkg::REQ_SET, bsf_pkg::REQ_REMOVE: req_kind = bsf_pkg::KIND_SCAN;
         default: req_kind = bsf_pkg::KIND_NONE;
      endcase
   end

   assign status.kind       = req_kind;
   assign scan_addr         = scan_idx_ff[IDX_W-1:0];
   assign issue             = cmd.scan && (scan_idx_ff < CNT_W'(TABLE_ENTRIES));
   assign hit               = rd_live_ff && rd_entry_ff[KEY_W] && (rd_entry_ff[KEY_W-1:0] == key_ff);
   assign status.scan_done  = hit || (!rd_live_ff && (scan_idx_ff == CNT_W'(TABLE_ENTRIES)));
   assign status.clear_done = (scan_idx_ff == CNT_W'(TABLE_ENTRIES - 1));
   assign finish            = cmd.scan && status.scan_done;
   assign free_any          = have_free_ff || (rd_live_ff && !rd_entry_ff[KEY_W]);
   assign free_pick         = have_free_ff ? free_idx_ff : rd_idx_ff;

   always_comb begin
      hdr_cnt_in     = hdr_cnt_ff;
      ether_in       = ether_ff;
      src_in         = src_ff;
      scan_idx_in    = scan_idx_ff;
      rd_live_in     = issue;
      have_free_in   = have_free_ff;
      free_idx_in    = free_idx_ff;
      res_verdict_in = res_verdict_ff;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      key_we         = 1'b0;
      key_wa         = scan_addr;
      key_wd         = '0;
      val_we         = 1'b0;
      val_wa         = rd_idx_ff;
      val_wd         = value_ff;

      if (cmd.clear) begin
         key_we      = 1'b1;
         scan_idx_in = status.clear_done ? '0 : scan_idx_ff + CNT_W'(1);
      end

      if (cmd.accept) begin
         scan_idx_in  = '0;
         have_free_in = 1'b0;
         if (req_type == bsf_pkg::REQ_FRAME) begin
            hdr_cnt_in = cnt_nx;
            ether_in   = ether_nx;
            src_in     = src_nx;
            if (last_byte) begin
               hdr_cnt_in = '0;
               ether_in   = '0;
               src_in     = '0;
            end
         end
         res_verdict_in = 1'b0;
         res_status_in  = bsf_pkg::ST_DONE;
         res_found_in   = 1'b0;
      end

      if (issue) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end
      if (rd_live_ff && !rd_entry_ff[KEY_W] && !have_free_ff) begin
         have_free_in = 1'b1;
         free_idx_in  = rd_idx_ff;
      end

      if (finish) begin
         rd_live_in = 1'b0;
         case (op_ff)
            bsf_pkg::REQ_SET: begin
               if (hit) begin
                  val_we       = 1'b1;
                  res_found_in = 1'b1;
               end else if (free_any) begin
                  key_we = 1'b1;
                  key_wa = free_pick;
                  key_wd = {1'b1, key_ff};
                  val_we = 1'b1;
                  val_wa = free_pick;
               end else begin
                  res_status_in = bsf_pkg::ST_FULL;
               end
            end
            bsf_pkg::REQ_REMOVE: begin
               if (hit) begin
                  key_we       = 1'b1;
                  key_wa       = rd_idx_ff;
                  key_wd       = {1'b0, rd_entry_ff[KEY_W-1:0]};
                  res_found_in = 1'b1;
               end else begin
                  res_status_in = bsf_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               // frame lookup: drop only a present entry marked blocked
               res_found_in   = hit;
               res_verdict_in = hit && (rd_val_ff == bsf_pkg::BLOCKED_VALUE);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff   <= '0;
         ether_ff     <= '0;
         src_ff       <= '0;
         scan_idx_ff  <= '0;
         rd_live_ff   <= 1'b0;
         have_free_ff <= 1'b0;
      end else begin
         hdr_cnt_ff   <= hdr_cnt_in;
         ether_ff     <= ether_in;
         src_ff       <= src_in;
         scan_idx_ff  <= scan_idx_in;
         rd_live_ff   <= rd_live_in;
         have_free_ff <= have_free_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff    <= free_idx_in;
      res_verdict_ff <= res_verdict_in;
      res_status_ff  <= res_status_in;
      res_found_ff   <= res_found_in;
      rd_idx_ff      <= scan_addr;
      if (cmd.accept) begin
         op_ff    <= req_type;
         key_ff   <= (req_type == bsf_pkg::REQ_FRAME) ? src_nx : table_key;
         value_ff <= table_value;
      end
      if (cmd.load_rsp) begin
         out_verdict_ff <= res_verdict_ff;
         out_status_ff  <= res_status_ff;
         out_found_ff   <= res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_wd;
      end
      rd_entry_ff <= key_mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= val_wd;
      end
      rd_val_ff <= val_mem[scan_addr];
   end

   assign verdict    = out_verdict_ff;
   assign rsp_status = out_status_ff;
   assign key_found  = out_found_ff;

endmodule

// File: hw/rtl/ipv4_source_blocklist_filter_top.sv
// Channel   Port       Role    Payload
// request   req_chan   sink    req_type, byte_value, last_byte, table_key, table_value
// response  rsp_chan   source  verdict, status, key_found
//
// A frame byte that is not the last yields no response.
// A last byte of a short or non-IPv4 frame gets a response without a scan; a lookup,
// set or remove scans the key memory through its single read port, one entry per cycle
// (a match ends the scan early; set and remove of an absent key always scan the whole
// table). After reset a clearing pass writes every entry of the key memory, resetting
// the valid marks; no request is taken during it.
// The response register holds until taken; frame bytes are still accepted meanwhile.
module ipv4_source_blocklist_filter_top #(
   parameter int TABLE_ENTRIES = bsf_pkg::TABLE_ENTRIES_DEF
) (
   input logic       clock,
   input logic       reset,
   bsf_req_if.sink   req_chan,
   bsf_rsp_if.source rsp_chan
);

   bsf_pkg::cmd_type    cmd;
   bsf_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   bsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsf_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_chan.req_type),
      .byte_value  (req_chan.byte_value),
      .last_byte   (req_chan.last_byte),
      .table_key   (req_chan.table_key),
      .table_value (req_chan.table_value),
      .verdict     (rsp_chan.verdict),
      .rsp_status  (rsp_chan.status),
      .key_found   (rsp_chan.key_found)
   );

`ifndef ASSERT_OFF
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !cmd.scan && !cmd.clear && !cmd.load_rsp)
      else $error("request accepted outside idle");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.scan && status.scan_done |=> !cmd.scan)
      else $error("scan continues after completion");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_chan.valid)
      else $error("loaded response not presented");

   a_clear_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.clear && status.clear_done |=> req_chan.ready)
      else $error("not ready after clearing pass");
`endif

endmodule
